>>> hw/rtl/emq_pkg.sv
`default_nettype none
package emq_pkg;

  localparam int DEPTH_DEF = 16;

  // operation codes
  localparam logic [2:0] FN_TICK  = 3'd0;
  localparam logic [2:0] FN_PUSH  = 3'd1;
  localparam logic [2:0] FN_MARK  = 3'd2;
  localparam logic [2:0] FN_ALL   = 3'd3;
  localparam logic [2:0] FN_CLEAR = 3'd4;
  localparam logic [2:0] FN_QUERY = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLED  = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;

  // one stored slot
  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  kind;
    logic [31:0] birth;
    logic [15:0] life;
    logic        rd;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

>>> hw/rtl/expiring_message_queue.sv
// a clear skips the slot walk below and empties the queue; an accepted push
// appends its new entry once the walk is done
// any other item walks every held slot once through the single read port of the
// slot memory, compacting in place, then the result is registered
// one item at a time; the next beat is taken once the result is registered
// reset (rst, synchronous): queue empty, clock and totals zero, enabled, capacity 16
// slot memory is not cleared; only slots below the fill count are read
`default_nettype none
module expiring_message_queue #(
  parameter int DEPTH = emq_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [15:0] tag,
  input  wire logic [2:0]  kind,
  input  wire logic [15:0] life_ticks,
  input  wire logic [15:0] elapsed_step,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ok,
  output logic [4:0]       held_count,
  output logic [4:0]       unread_count,
  output logic [4:0]       kind_count,
  output logic [31:0]      pushed_total,
  output logic [31:0]      expired_total,
  output logic             recent_valid,
  output logic [15:0]      recent_tag,
  output logic [2:0]       recent_kind,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_APP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    st;
  logic          enabled;
  logic [4:0]    capacity;
  logic [CW-1:0] fill;
  logic [31:0]   clock_ticks;
  logic [31:0]   push_tally;
  logic [31:0]   expire_tally;

  // latched item
  logic [2:0]    q_func;
  logic [15:0]   q_tag;
  logic [2:0]    q_kind;
  logic [15:0]   q_life;
  logic          q_tick;
  logic          q_push;
  logic          q_evict;

  // pass control
  logic [CW-1:0] rd;
  logic [CW-1:0] wr;
  logic [CW-1:0] pidx;
  logic          pv;
  logic          mfound;

  // result accumulators
  logic [CW-1:0] un;
  logic [CW-1:0] kc;
  logic          bf;
  logic [31:0]   bage;
  logic [15:0]   btag;
  logic [2:0]    bkind;

  // memory ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  emq_pkg::entry_t        ram_wdata;
  logic [emq_pkg::ENTRY_W-1:0] ram_rdata;
  emq_pkg::entry_t        cur;
  emq_pkg::entry_t        mod;
  emq_pkg::entry_t        newe;
  emq_pkg::entry_t        acc_e;
  logic                   keep;
  logic                   expire;
  logic                   mark_hit;
  logic                   acc_en;
  logic [31:0]            acc_age;
  logic                   acc_best;
  logic                   pass_done;
  logic                   out_load;
  int                     effcap;

  emq_ram #(.WIDTH(emq_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall  = (st != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cur       = emq_pkg::entry_t'(ram_rdata);
  assign pass_done = (rd >= fill) && !pv;
  assign out_load  = !out_valid || !out_stall;

  // effective capacity
  always_comb begin
    effcap = int'(capacity);
    if (effcap < 1) effcap = 1;
    if (effcap > DEPTH) effcap = DEPTH;
  end

  // new entry for an accepted push
  always_comb begin
    newe.tag   = q_tag;
    newe.kind  = q_kind;
    newe.birth = clock_ticks;
    newe.life  = q_life;
    newe.rd    = 1'b0;
  end

  // per-slot update of the pass
  always_comb begin
    mod      = cur;
    expire   = q_tick && ((clock_ticks - cur.birth) >= 32'(cur.life));
    keep     = !expire && !(q_evict && pidx == '0);
    mark_hit = (q_func == emq_pkg::FN_MARK) && !mfound && q_tag != 16'd0 &&
               cur.tag == q_tag;
    if (mark_hit || q_func == emq_pkg::FN_ALL) mod.rd = 1'b1;
  end

  // write port and stats feed
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr[AW-1:0];
    ram_wdata = mod;
    acc_en    = 1'b0;
    acc_e     = mod;
    if (st == ST_RUN && pv && keep) begin
      ram_we = 1'b1;
      acc_en = 1'b1;
    end else if (st == ST_APP) begin
      ram_we    = 1'b1;
      ram_wdata = newe;
      acc_e     = newe;
      acc_en    = 1'b1;
    end
    acc_age  = clock_ticks - acc_e.birth;
    acc_best = !bf || (acc_age < bage);
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      enabled      <= 1'b1;
      capacity     <= 5'd16;
      fill         <= '0;
      clock_ticks  <= '0;
      push_tally   <= '0;
      expire_tally <= '0;
      out_valid    <= 1'b0;
      pv           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == emq_pkg::CFG_ENABLED) enabled <= cfg_data[0];
        else if (cfg_index == emq_pkg::CFG_CAPACITY) capacity <= cfg_data;
      end

      // result beat: raise on a finished item, drop once taken
      if (st == ST_FIN && out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (st)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            q_func  <= func;
            q_tag   <= tag;
            q_kind  <= kind;
            q_life  <= life_ticks;
            q_tick  <= (func == emq_pkg::FN_TICK) && enabled;
            q_push  <= (func == emq_pkg::FN_PUSH) && tag != 16'd0 && life_ticks != 16'd0;
            q_evict <= (func == emq_pkg::FN_PUSH) && tag != 16'd0 && life_ticks != 16'd0 &&
                       fill != '0 && int'(fill) >= effcap;
            if (func == emq_pkg::FN_TICK && enabled)
              clock_ticks <= clock_ticks + 32'(elapsed_step);
            rd     <= '0;
            wr     <= '0;
            pv     <= 1'b0;
            mfound <= 1'b0;
            un     <= '0;
            kc     <= '0;
            bf     <= 1'b0;
            bage   <= '0;
            btag   <= '0;
            bkind  <= '0;
            st     <= (func == emq_pkg::FN_CLEAR) ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          if (rd < fill) begin
            rd <= rd + 1'b1;
            pv <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          pidx <= rd;
          if (pv) begin
            if (expire) expire_tally <= expire_tally + 32'd1;
            if (mark_hit) mfound <= 1'b1;
            if (keep) wr <= wr + 1'b1;
          end
          if (pass_done) st <= q_push ? ST_APP : ST_FIN;
        end
        ST_APP: begin
          wr         <= wr + 1'b1;
          push_tally <= push_tally + 32'd1;
          st         <= ST_FIN;
        end
        ST_FIN: begin
          fill <= wr;
          if (out_load) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase

      // stats over kept and appended slots
      if (acc_en) begin
        if (acc_e.kind == q_kind) kc <= kc + 1'b1;
        if (!acc_e.rd) begin
          un <= un + 1'b1;
          if (acc_best) begin
            bf    <= 1'b1;
            bage  <= acc_age;
            btag  <= acc_e.tag;
            bkind <= acc_e.kind;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (st == ST_FIN && out_load) begin
      priority case (1'b1)
        q_func == emq_pkg::FN_TICK: ok <= q_tick;
        q_func == emq_pkg::FN_PUSH: ok <= q_push;
        q_func == emq_pkg::FN_MARK: ok <= mfound;
        q_func == emq_pkg::FN_ALL || q_func == emq_pkg::FN_CLEAR ||
          q_func == emq_pkg::FN_QUERY: ok <= 1'b1;
        default: ok <= 1'b0;
      endcase
      held_count    <= 5'(wr);
      unread_count  <= 5'(un);
      kind_count    <= 5'(kc);
      pushed_total  <= push_tally;
      expired_total <= expire_tally;
      recent_valid  <= bf;
      recent_tag    <= bf ? btag : 16'd0;
      recent_kind   <= bf ? bkind : 3'd0;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= DEPTH) else $error("fill above depth");
  a_compact: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RUN) |-> (wr <= rd)) else $error("write ahead of read");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FIN) |=> !pv) else $error("pending read after pass");

endmodule
`default_nettype wire

>>> hw/rtl/emq_ram.sv
`default_nettype none
module emq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> dv/tb.sv
`default_nettype none
module tb;

  localparam int DEPTH = emq_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] tag;
    logic [2:0]  kind;
    logic [15:0] life_ticks;
    logic [15:0] elapsed_step;
  } op_t;

  typedef struct packed {
    logic        ok;
    logic [4:0]  held_count;
    logic [4:0]  unread_count;
    logic [4:0]  kind_count;
    logic [31:0] pushed_total;
    logic [31:0] expired_total;
    logic        recent_valid;
    logic [15:0] recent_tag;
    logic [2:0]  recent_kind;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic [15:0] tag = '0;
  logic [2:0] kind = '0;
  logic [15:0] life_ticks = '0;
  logic [15:0] elapsed_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok;
  logic [4:0] held_count, unread_count, kind_count;
  logic [31:0] pushed_total, expired_total;
  logic recent_valid;
  logic [15:0] recent_tag;
  logic [2:0] recent_kind;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  expiring_message_queue dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the queue contents
  emq_pkg::entry_t q_slot [DEPTH];
  int unsigned q_fill;
  logic [31:0] q_clock, q_pushes, q_expiries;
  logic q_enabled;
  logic [4:0] q_capacity;

  op_t pending_ops[$];
  status_t expected_status[$];
  int errors = 0;
  int ops_sent = 0;
  int status_seen = 0;
  bit driver_hold = 0;
  longint cycles = 0;

  function automatic status_t apply_op(op_t op);
    status_t s;
    int unsigned cap, w, unread, kc;
    logic [31:0] age, best_age;
    bit found;
    emq_pkg::entry_t best;
    s = '0;
    cap = (q_capacity < 5'd1) ? 1 : (int'(q_capacity) > DEPTH) ? DEPTH : int'(q_capacity);
    best = '0;
    best_age = '0;
    found = 0;
    unread = 0;
    kc = 0;
    case (op.func)
      emq_pkg::FN_TICK: begin
        if (q_enabled) begin
          q_clock += 32'(op.elapsed_step);
          w = 0;
          for (int i = 0; i < q_fill; i++) begin
            age = q_clock - q_slot[i].birth;
            if (age >= 32'(q_slot[i].life)) q_expiries++;
            else begin
              q_slot[w] = q_slot[i];
              w++;
            end
          end
          q_fill = w;
          s.ok = 1'b1;
        end
      end
      emq_pkg::FN_PUSH: begin
        if (op.tag != 16'd0 && op.life_ticks != 16'd0) begin
          if (q_fill >= cap && q_fill > 0) begin
            for (int i = 1; i < q_fill; i++) q_slot[i-1] = q_slot[i];
            q_fill--;
          end
          q_slot[q_fill] = '{op.tag, op.kind, q_clock, op.life_ticks, 1'b0};
          q_fill++;
          q_pushes++;
          s.ok = 1'b1;
        end
      end
      emq_pkg::FN_MARK: begin
        for (int i = 0; i < q_fill; i++)
          if (!s.ok && op.tag != 16'd0 && q_slot[i].tag == op.tag) begin
            q_slot[i].rd = 1'b1;
            s.ok = 1'b1;
          end
      end
      emq_pkg::FN_ALL: begin
        for (int i = 0; i < q_fill; i++) q_slot[i].rd = 1'b1;
        s.ok = 1'b1;
      end
      emq_pkg::FN_CLEAR: begin
        q_fill = 0;
        s.ok = 1'b1;
      end
      emq_pkg::FN_QUERY: s.ok = 1'b1;
      default: s.ok = 1'b0;
    endcase
    for (int i = 0; i < q_fill; i++) begin
      if (q_slot[i].kind == op.kind) kc++;
      if (!q_slot[i].rd) begin
        age = q_clock - q_slot[i].birth;
        unread++;
        if (!found || age < best_age) begin
          found = 1;
          best = q_slot[i];
          best_age = age;
        end
      end
    end
    s.held_count = 5'(q_fill);
    s.unread_count = 5'(unread);
    s.kind_count = 5'(kc);
    s.pushed_total = q_pushes;
    s.expired_total = q_expiries;
    s.recent_valid = found;
    s.recent_tag = found ? best.tag : '0;
    s.recent_kind = found ? best.kind : '0;
    return s;
  endfunction

  function automatic op_t make_op(logic [2:0] f, logic [15:0] t, logic [2:0] k,
                                  logic [15:0] l, logic [15:0] e);
    op_t op;
    op = '{f, t, k, l, e};
    return op;
  endfunction

  // append to the pending and expected lists
  task automatic queue_op(op_t op);
    pending_ops = {pending_ops, op};
  endtask

  task automatic queue_status(status_t s);
    expected_status = {expected_status, s};
  endtask

  // random op: pushes most often, with a small tag pool so marks hit
  function automatic op_t random_op();
    op_t op;
    int r;
    r = $urandom_range(0, 99);
    op.tag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    op.kind = 3'($urandom);
    op.life_ticks = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 40));
    op.elapsed_step = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 12));
    if (r < 40) op.func = emq_pkg::FN_PUSH;
    else if (r < 65) op.func = emq_pkg::FN_TICK;
    else if (r < 78) op.func = emq_pkg::FN_MARK;
    else if (r < 83) op.func = emq_pkg::FN_ALL;
    else if (r < 86) op.func = emq_pkg::FN_CLEAR;
    else if (r < 94) op.func = emq_pkg::FN_QUERY;
    else op.func = 3'($urandom_range(6, 7));
    return op;
  endfunction

  // driver: one beat per pending op with a random gap before each, some stretches none
  int send_gap = 0;
  always @(posedge clk) begin
    op_t sent_op;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sent_op = pending_ops.pop_front();
        queue_status(apply_op(sent_op));
        ops_sent++;
        in_valid <= 1'b0;
        send_gap = (ops_sent % 200 < 30) ? 0 : $urandom_range(0, 18);
      end else if (!in_valid && !driver_hold && pending_ops.size() > 0) begin
        if (send_gap > 0) send_gap--;
        else begin
          in_valid <= 1'b1;
          func <= pending_ops[0].func;
          tag <= pending_ops[0].tag;
          kind <= pending_ops[0].kind;
          life_ticks <= pending_ops[0].life_ticks;
          elapsed_step <= pending_ops[0].elapsed_step;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    status_t exp_s;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) begin
        status_seen++;
        if (expected_status.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_s = expected_status.pop_front();
          if (ok !== exp_s.ok) begin
            $error("ok exp %0d got %0d", exp_s.ok, ok); errors++;
          end
          if (held_count !== exp_s.held_count) begin
            $error("held_count exp %0d got %0d", exp_s.held_count, held_count); errors++;
          end
          if (unread_count !== exp_s.unread_count) begin
            $error("unread_count exp %0d got %0d", exp_s.unread_count, unread_count);
            errors++;
          end
          if (kind_count !== exp_s.kind_count) begin
            $error("kind_count exp %0d got %0d", exp_s.kind_count, kind_count); errors++;
          end
          if (pushed_total !== exp_s.pushed_total) begin
            $error("pushed_total exp %0d got %0d", exp_s.pushed_total, pushed_total);
            errors++;
          end
          if (expired_total !== exp_s.expired_total) begin
            $error("expired_total exp %0d got %0d", exp_s.expired_total, expired_total);
            errors++;
          end
          if (recent_valid !== exp_s.recent_valid) begin
            $error("recent_valid exp %0d got %0d", exp_s.recent_valid, recent_valid);
            errors++;
          end
          if (recent_tag !== exp_s.recent_tag) begin
            $error("recent_tag exp %0d got %0d", exp_s.recent_tag, recent_tag); errors++;
          end
          if (recent_kind !== exp_s.recent_kind) begin
            $error("recent_kind exp %0d got %0d", exp_s.recent_kind, recent_kind); errors++;
          end
        end
      end
      // receiver stall: a fresh random hold after each beat, some stretches none
      if (out_valid && !out_stall) stall_left = (status_seen % 150 < 25) ? 0
                                                : $urandom_range(0, 18);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_status.size() > 0)
      @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == emq_pkg::CFG_ENABLED) q_enabled = val[0];
    else q_capacity = val;
  endtask

  // one phase of random traffic, with a drain pause in the middle
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) queue_op(random_op());
    while (pending_ops.size() > n / 2) @(posedge clk);
    driver_hold = 1;
    while (in_valid || expected_status.size() > 0) @(posedge clk);
    driver_hold = 0;
    wait_drained();
  endtask

  initial begin
    logic [4:0] caps [6];
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8};
    q_fill = 0;
    q_clock = '0;
    q_pushes = '0;
    q_expiries = '0;
    q_enabled = 1'b1;
    q_capacity = 5'd16;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, refusals, every operation
    queue_op(make_op(emq_pkg::FN_QUERY, 16'd0, 3'd0, 16'd0, 16'd0));
    queue_op(make_op(emq_pkg::FN_PUSH, 16'd0, 3'd1, 16'd5, 16'd0));
    queue_op(make_op(emq_pkg::FN_PUSH, 16'hFFFF, 3'd7, 16'd0, 16'd0));
    queue_op(make_op(emq_pkg::FN_PUSH, 16'hFFFF, 3'd7, 16'hFFFF, 16'hFFFF));
    queue_op(make_op(emq_pkg::FN_PUSH, 16'd1, 3'd0, 16'd1, 16'd0));
    queue_op(make_op(emq_pkg::FN_PUSH, 16'd1, 3'd3, 16'd3, 16'd0));
    queue_op(make_op(emq_pkg::FN_TICK, 16'd0, 3'd0, 16'd0, 16'd0));
    queue_op(make_op(emq_pkg::FN_TICK, 16'd0, 3'd3, 16'd0, 16'd1));
    queue_op(make_op(emq_pkg::FN_MARK, 16'd0, 3'd7, 16'd0, 16'd0));
    queue_op(make_op(emq_pkg::FN_MARK, 16'hFFFF, 3'd7, 16'd0, 16'd0));
    queue_op(make_op(emq_pkg::FN_MARK, 16'd1234, 3'd7, 16'd0, 16'd0));
    queue_op(make_op(emq_pkg::FN_PUSH, 16'd2, 3'd5, 16'd100, 16'd0));
    queue_op(make_op(emq_pkg::FN_ALL, 16'd0, 3'd5, 16'd0, 16'd0));
    queue_op(make_op(3'd6, 16'd0, 3'd5, 16'd0, 16'd0));
    queue_op(make_op(3'd7, 16'hFFFF, 3'd7, 16'hFFFF, 16'hFFFF));
    queue_op(make_op(emq_pkg::FN_TICK, 16'd0, 3'd0, 16'd0, 16'hFFFF));
    queue_op(make_op(emq_pkg::FN_CLEAR, 16'd0, 3'd0, 16'd0, 16'd0));
    for (int i = 0; i < 6; i++)
      queue_op(make_op(emq_pkg::FN_PUSH, 16'(i + 10), 3'(i), 16'(2 + i), 16'd0));
    queue_op(make_op(emq_pkg::FN_TICK, 16'd0, 3'd2, 16'd0, 16'd4));
    wait_drained();

    // sweep capacity and enable, extremes included
    for (int p = 0; p < 6; p++) begin
      write_reg(emq_pkg::CFG_CAPACITY, caps[p]);
      write_reg(emq_pkg::CFG_ENABLED, 5'(p != 2));
      random_phase(260);
    end
    write_reg(emq_pkg::CFG_ENABLED, 5'd1);
    write_reg(emq_pkg::CFG_CAPACITY, 5'd16);
    random_phase(60);

    $display("covered %0d operations, %0d results checked, capacities 0..31, enable on/off",
             ops_sent, status_seen);
    if (errors == 0 && expected_status.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
